// ===== design/llsf_pkg.sv =====
// shared types and constants of the least-squares line fit
package llsf_pkg;

  // fraction bits of the incoming sample coordinates
  localparam int IN_FRAC_BITS = 8;

  // width of the slope and intercept results
  localparam int RES_W = 32;

  // running quotient: wide enough to hold the clamp value and detect saturation
  localparam int QUOT_W = 34;
  localparam logic [QUOT_W-1:0] QUOT_CAP = 34'h2_0000_0000;
  localparam logic [QUOT_W-1:0] QUOT_POS_LIM = 34'h0_7FFF_FFFF;
  localparam logic [QUOT_W-1:0] QUOT_NEG_LIM = 34'h0_8000_0000;

  // status and results handed from the fit engine to the top level
  typedef struct packed {
    logic             done;
    logic             degenerate;
    logic [RES_W-1:0] slope;
    logic [RES_W-1:0] intercept;
  } fit_res_t;

endpackage

// ===== design/llsf_fit_engine.sv =====
// fit engine: serial multiply-accumulate and restoring divide on one shared adder
module llsf_fit_engine #(
  parameter int CNT_W            = 13,
  parameter int SX_W             = 29,
  parameter int SQ_W             = 45,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [CNT_W-1:0]       cnt_i,
  input  logic signed [SX_W-1:0] sx_i,
  input  logic signed [SX_W-1:0] sy_i,
  input  logic signed [SQ_W-1:0] sxx_i,
  input  logic signed [SQ_W-1:0] sxy_i,
  output llsf_pkg::fit_res_t     res_o
);

  // numerator and denominator width, and the shared adder width
  localparam int NUM_W       = SQ_W + SX_W + 1;
  localparam int AW          = NUM_W + 1;
  localparam int SLOPE_ITERS = NUM_W + RESULT_FRAC_BITS;
  localparam int ICPT_ITERS  = NUM_W + RESULT_FRAC_BITS - llsf_pkg::IN_FRAC_BITS;
  localparam int ITER_W      = $clog2(SLOPE_ITERS + 1);
  localparam int QW          = llsf_pkg::QUOT_W;
  localparam int RW          = llsf_pkg::RES_W;

  typedef enum logic [2:0] {
    E_IDLE,
    E_LOAD,
    E_MAC,
    E_DIV,
    E_FIN
  } eng_state_e;

  // product terms in the order they are accumulated
  typedef enum logic [2:0] {
    TERM_N_SXX,
    TERM_SX_SX,
    TERM_N_SXY,
    TERM_SX_SY,
    TERM_SXX_SY,
    TERM_SX_SXY
  } term_e;

  eng_state_e           state_q;
  term_e                term_q;
  logic [AW-1:0]        acc_q;
  logic [AW-1:0]        mcand_q;
  logic [SX_W-1:0]      mplr_q;
  logic                 negop_q;
  logic [NUM_W-1:0]     den_q;
  logic [NUM_W-1:0]     dvd_q;
  logic [QW-1:0]        quot_q;
  logic                 qneg_q;
  logic [ITER_W-1:0]    iter_q;
  logic [RW-1:0]        slope_q;
  logic [RW-1:0]        icpt_q;
  logic                 degen_q;

  // operand selection for the current product term
  logic signed [SQ_W-1:0] mcand_sel;
  logic signed [SX_W-1:0] mplr_sel;
  logic                   term_sub;
  term_e                  term_nxt;
  logic [SX_W-1:0]        n_ext;

  assign n_ext = {{(SX_W-CNT_W){1'b0}}, cnt_i};

  always_comb begin
    mcand_sel = sxx_i;
    mplr_sel  = n_ext;
    term_sub  = 1'b0;
    term_nxt  = TERM_SX_SX;
    unique case (term_q)
      TERM_N_SXX: begin
        mcand_sel = sxx_i;
        mplr_sel  = n_ext;
        term_sub  = 1'b0;
        term_nxt  = TERM_SX_SX;
      end
      TERM_SX_SX: begin
        mcand_sel = {{(SQ_W-SX_W){sx_i[SX_W-1]}}, sx_i};
        mplr_sel  = sx_i;
        term_sub  = 1'b1;
        term_nxt  = TERM_N_SXY;
      end
      TERM_N_SXY: begin
        mcand_sel = sxy_i;
        mplr_sel  = n_ext;
        term_sub  = 1'b0;
        term_nxt  = TERM_SX_SY;
      end
      TERM_SX_SY: begin
        mcand_sel = {{(SQ_W-SX_W){sy_i[SX_W-1]}}, sy_i};
        mplr_sel  = sx_i;
        term_sub  = 1'b1;
        term_nxt  = TERM_SXX_SY;
      end
      TERM_SXX_SY: begin
        mcand_sel = sxx_i;
        mplr_sel  = sy_i;
        term_sub  = 1'b0;
        term_nxt  = TERM_SX_SXY;
      end
      TERM_SX_SXY: begin
        mcand_sel = sxy_i;
        mplr_sel  = sx_i;
        term_sub  = 1'b1;
        term_nxt  = TERM_N_SXX;
      end
      default: begin
        mcand_sel = sxx_i;
        mplr_sel  = n_ext;
        term_sub  = 1'b0;
        term_nxt  = TERM_N_SXX;
      end
    endcase
  end

  // shared adder: accumulate in multiply steps, trial subtract in divide steps
  logic [AW-1:0] rem_sh;
  logic [AW-1:0] op_a;
  logic [AW-1:0] op_b;
  logic          op_sub;
  logic [AW-1:0] add_sum;

  assign rem_sh = {acc_q[AW-2:0], dvd_q[NUM_W-1]};

  always_comb begin
    op_a   = acc_q;
    op_b   = '0;
    op_sub = 1'b0;
    case (state_q)
      E_MAC: begin
        op_a   = acc_q;
        op_b   = mcand_q;
        op_sub = negop_q;
      end
      E_DIV: begin
        op_a   = rem_sh;
        op_b   = {1'b0, den_q};
        op_sub = 1'b1;
      end
      default: begin
        op_a   = acc_q;
        op_b   = '0;
        op_sub = 1'b0;
      end
    endcase
  end

  assign add_sum = op_a + (op_b ^ {AW{op_sub}}) + {{(AW-1){1'b0}}, op_sub};

  // magnitudes for loading the multiplier and the dividend
  logic [SX_W-1:0] mplr_mag;
  logic [AW-1:0]   acc_mag;
  logic            acc_nonpos;

  assign mplr_mag   = mplr_sel[SX_W-1] ? (~mplr_sel + 1'b1) : mplr_sel;
  assign acc_mag    = acc_q[AW-1] ? (~acc_q + 1'b1) : acc_q;
  assign acc_nonpos = acc_q[AW-1] || (acc_q == '0);

  // quotient bit, clamped running quotient and final saturation
  logic          div_ge;
  logic [QW:0]   quot_wide;
  logic [QW-1:0] quot_nxt;
  logic [QW-1:0] quot_lim;
  logic [QW-1:0] quot_sat;
  logic [RW-1:0] quot_res;

  assign div_ge    = ~add_sum[AW-1];
  assign quot_wide = {quot_q, div_ge};
  assign quot_nxt  = (quot_wide > {1'b0, llsf_pkg::QUOT_CAP}) ? llsf_pkg::QUOT_CAP
                                                              : quot_wide[QW-1:0];
  assign quot_lim  = qneg_q ? llsf_pkg::QUOT_NEG_LIM : llsf_pkg::QUOT_POS_LIM;
  assign quot_sat  = (quot_q > quot_lim) ? quot_lim : quot_q;
  assign quot_res  = qneg_q ? (~quot_sat[RW-1:0] + 1'b1) : quot_sat[RW-1:0];

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      term_q  <= TERM_N_SXX;
      acc_q   <= '0;
      mcand_q <= '0;
      mplr_q  <= '0;
      negop_q <= 1'b0;
      den_q   <= '0;
      dvd_q   <= '0;
      quot_q  <= '0;
      qneg_q  <= 1'b0;
      iter_q  <= '0;
      slope_q <= '0;
      icpt_q  <= '0;
      degen_q <= 1'b0;
    end else begin
      unique case (state_q)
        E_IDLE: begin
          if (start_i) begin
            acc_q   <= '0;
            term_q  <= TERM_N_SXX;
            degen_q <= 1'b0;
            state_q <= E_LOAD;
          end
        end
        E_LOAD: begin
          mcand_q <= {{(AW-SQ_W){mcand_sel[SQ_W-1]}}, mcand_sel};
          mplr_q  <= mplr_mag;
          negop_q <= mplr_sel[SX_W-1] ^ term_sub;
          state_q <= E_MAC;
        end
        E_MAC: begin
          if (mplr_q != '0) begin
            if (mplr_q[0]) begin
              acc_q <= add_sum;
            end
            mcand_q <= {mcand_q[AW-2:0], 1'b0};
            mplr_q  <= {1'b0, mplr_q[SX_W-1:1]};
          end else begin
            case (term_q)
              TERM_SX_SX: begin
                // denominator complete: zero or negative means no fit
                den_q <= acc_q[NUM_W-1:0];
                if (acc_nonpos) begin
                  degen_q <= 1'b1;
                  slope_q <= '0;
                  icpt_q  <= '0;
                  state_q <= E_FIN;
                end else begin
                  acc_q   <= '0;
                  term_q  <= term_nxt;
                  state_q <= E_LOAD;
                end
              end
              TERM_SX_SY, TERM_SX_SXY: begin
                // numerator complete: start the long division
                qneg_q  <= acc_q[AW-1];
                dvd_q   <= acc_mag[NUM_W-1:0];
                acc_q   <= '0;
                quot_q  <= '0;
                iter_q  <= (term_q == TERM_SX_SY) ? ITER_W'(SLOPE_ITERS)
                                                  : ITER_W'(ICPT_ITERS);
                state_q <= E_DIV;
              end
              default: begin
                term_q  <= term_nxt;
                state_q <= E_LOAD;
              end
            endcase
          end
        end
        E_DIV: begin
          if (iter_q != '0) begin
            acc_q  <= div_ge ? add_sum : rem_sh;
            dvd_q  <= {dvd_q[NUM_W-2:0], 1'b0};
            quot_q <= quot_nxt;
            iter_q <= iter_q - 1'b1;
          end else if (term_q == TERM_SX_SY) begin
            slope_q <= quot_res;
            acc_q   <= '0;
            term_q  <= term_nxt;
            state_q <= E_LOAD;
          end else begin
            icpt_q  <= quot_res;
            state_q <= E_FIN;
          end
        end
        E_FIN: begin
          state_q <= E_IDLE;
        end
        default: begin
          state_q <= E_IDLE;
        end
      endcase
    end
  end

  assign res_o.done       = (state_q == E_FIN);
  assign res_o.degenerate = degen_q;
  assign res_o.slope      = slope_q;
  assign res_o.intercept  = icpt_q;

endmodule

// ===== design/linear_least_squares_fit.sv =====
// streaming least-squares straight-line fit, top level
//
//  channel | direction | signals                                        | handshake
//  --------+-----------+------------------------------------------------+-----------------
//  in      | input     | x_sample_i, y_sample_i, last_i                 | in_valid_i/in_ready_o
//  out     | output    | slope_o, intercept_o, degenerate_o,            | out_valid_o/out_ready_i
//          |           | overflowed_o, points_used_o                    |
//
// A point passes capture, the x*x and x*y products and accumulation in turn;
// the next point is taken only after that. A point marked last then runs the fit
// in the shared adder of the engine: six serial products and two long divisions.
// Reset clears the sums and the count at once; no clearing pass is needed.
// A waiting result does not block the next set: points are taken again as soon
// as the result is in the output register, and a stalled output only holds a
// finished fit until the previous result has been taken.
module linear_least_squares_fit #(
  parameter int MAX_POINTS       = 4096,
  parameter int SAMPLE_WIDTH     = 16,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]          x_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]          y_sample_i,
  input  logic                                    last_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [llsf_pkg::RES_W-1:0]       slope_o,
  output logic signed [llsf_pkg::RES_W-1:0]       intercept_o,
  output logic                                    degenerate_o,
  output logic                                    overflowed_o,
  output logic [$clog2(MAX_POINTS+1)-1:0]         points_used_o
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SX_W  = SW + CNT_W;
  localparam int SQ_W  = 2 * SW + CNT_W;
  localparam int PR_W  = 2 * SW;
  localparam int RW    = llsf_pkg::RES_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_ACC,
    S_FIT,
    S_DONE
  } top_state_e;

  top_state_e             state_q;
  logic signed [SW-1:0]   x_q;
  logic signed [SW-1:0]   y_q;
  logic                   last_q;
  logic signed [PR_W-1:0] xx_q;
  logic signed [PR_W-1:0] xy_q;
  logic [CNT_W-1:0]       cnt_q;
  logic signed [SX_W-1:0] sx_q;
  logic signed [SX_W-1:0] sy_q;
  logic signed [SQ_W-1:0] sxx_q;
  logic signed [SQ_W-1:0] sxy_q;
  logic                   cap_q;
  logic                   start_q;
  logic                   out_valid_q;
  logic [RW-1:0]          slope_q;
  logic [RW-1:0]          icpt_q;
  logic                   degen_q;
  logic                   ovf_q;
  logic [CNT_W-1:0]       used_q;

  llsf_pkg::fit_res_t     fit_res;

  // widened operands for the per-point products
  logic signed [PR_W-1:0] x_ext;
  logic signed [PR_W-1:0] y_ext;
  logic                   full;
  logic                   out_load;

  assign x_ext    = {{SW{x_q[SW-1]}}, x_q};
  assign y_ext    = {{SW{y_q[SW-1]}}, y_q};
  assign full     = (cnt_q == CNT_W'(MAX_POINTS));
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign in_ready_o = (state_q == S_IDLE);

  // point capture, accumulation and result hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      last_q      <= 1'b0;
      xx_q        <= '0;
      xy_q        <= '0;
      cnt_q       <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxx_q       <= '0;
      sxy_q       <= '0;
      cap_q       <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      slope_q     <= '0;
      icpt_q      <= '0;
      degen_q     <= 1'b0;
      ovf_q       <= 1'b0;
      used_q      <= '0;
    end else begin
      // engine start pulse when the last point is folded in
      start_q <= (state_q == S_ACC) && last_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            x_q     <= x_sample_i;
            y_q     <= y_sample_i;
            last_q  <= last_i;
            state_q <= S_PROD;
          end
        end
        S_PROD: begin
          xx_q    <= x_ext * x_ext;
          xy_q    <= x_ext * y_ext;
          state_q <= S_ACC;
        end
        S_ACC: begin
          // a point beyond capacity is dropped but may still close the set
          if (full) begin
            cap_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            sx_q  <= sx_q + {{CNT_W{x_q[SW-1]}}, x_q};
            sy_q  <= sy_q + {{CNT_W{y_q[SW-1]}}, y_q};
            sxx_q <= sxx_q + {{CNT_W{xx_q[PR_W-1]}}, xx_q};
            sxy_q <= sxy_q + {{CNT_W{xy_q[PR_W-1]}}, xy_q};
          end
          if (last_q) begin
            state_q <= S_FIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FIT: begin
          if (fit_res.done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // move the fit to the output register and clear for the next set
          if (out_load) begin
            slope_q <= fit_res.slope;
            icpt_q  <= fit_res.intercept;
            degen_q <= fit_res.degenerate;
            ovf_q   <= cap_q;
            used_q  <= cnt_q;
            cnt_q   <= '0;
            sx_q    <= '0;
            sy_q    <= '0;
            sxx_q   <= '0;
            sxy_q   <= '0;
            cap_q   <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // slope and intercept from the held sums
  llsf_fit_engine #(
    .CNT_W            (CNT_W),
    .SX_W             (SX_W),
    .SQ_W             (SQ_W),
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .cnt_i   (cnt_q),
    .sx_i    (sx_q),
    .sy_i    (sy_q),
    .sxx_i   (sxx_q),
    .sxy_i   (sxy_q),
    .res_o   (fit_res)
  );

  assign out_valid_o   = out_valid_q;
  assign slope_o       = slope_q;
  assign intercept_o   = icpt_q;
  assign degenerate_o  = degen_q;
  assign overflowed_o  = ovf_q;
  assign points_used_o = used_q;

`ifndef SYNTH
  // the held count never passes capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  // the engine only finishes while the top level waits for it
  a_done_in_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fit_res.done |-> state_q == S_FIT)
    else $error("fit finished outside the fit state");

  // a degenerate fit carries zero slope and intercept
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> slope_o == '0 && intercept_o == '0)
    else $error("degenerate fit with non-zero results");

  // dropped points imply a full set
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflowed_o |-> points_used_o == CNT_W'(MAX_POINTS))
    else $error("overflow flagged below capacity");
`endif

endmodule
